>>> src/tdcc_pkg.sv
// Package: shared types and constants of the TDC code-density calibrator.
`default_nettype none
package tdcc_pkg;

  localparam logic [1:0] CMD_ACCUM     = 2'd0;
  localparam logic [1:0] CMD_CONVERT   = 2'd1;
  localparam logic [1:0] CMD_RECOMPUTE = 2'd2;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_ZERO  = 2'd1;
  localparam logic [1:0] STS_RANGE = 2'd2;

  localparam logic [15:0] PERIOD_RESET   = 16'd2560;
  localparam logic [15:0] MIN_HITS_RESET = 16'd10;

  localparam logic REG_PERIOD   = 1'b0;
  localparam logic REG_MIN_HITS = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_HIT_RD, ST_HIT_WR, ST_PREP, ST_SUM,
    ST_SUM_END, ST_TEST, ST_BIN_RD, ST_BIN_MUL, ST_BIN_ACC, ST_DIV_W,
    ST_DIV_S, ST_TBL, ST_NEXT, ST_CONV_RD, ST_CONV_MUL, ST_RESP
  } state_t;

  typedef struct packed {
    logic       load;
    logic       clr_wr;
    logic       hit_rd;
    logic       hit_wr;
    logic       sum_init;
    logic       sum_rd;
    logic       bin_init;
    logic       bin_rd;
    logic       bin_mul;
    logic       bin_acc;
    logic       div_start_s;
    logic       bin_wr;
    logic       tbl_wr;
    logic       conv_rd;
    logic       conv_mul;
    logic       emit;
    logic       rec;
    logic [1:0] tsel;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       le;
    logic       te;
    logic       neg;
    logic       err;
    logic       raise;
    logic       sweep_last;
    logic       idx_last;
    logic       total_ok;
    logic       div_done;
  } sts_t;

endpackage
`default_nettype wire

>>> src/tdc_code_density_calibrator_unit.sv
// Top level: TDC code-density calibrator with APB-style register port.
`default_nettype none
// Code-density calibrator for a delay-line TDC. Four histograms (leading or
// trailing edge, positive or negative phase) count hits per phase bin; a
// table is rebuilt into bin start times and widths (1/256 ns units) when a
// hit raises its largest phase and it holds at least min_hits counts.
// An item is taken when start is high and busy low; its one result shows on
// the out_ ports for one cycle with out_valid and cannot be stalled.
// Accumulating a hit updates one table, or both when both edge flags are set.
// A hit that raises a table's largest phase adds a count pass over its bins;
// if the table then holds enough counts it is rebuilt: per bin a memory
// read, a multiply and two divisions in the shared divider. A recompute-all
// command runs the count pass and any rebuild over all four tables.
// After reset a clear pass initializes the memories, with busy high;
// register writes are taken during it.
module tdc_code_density_calibrator_unit #(
  parameter int NUM_BINS = 128
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_command,
  input  wire logic              in_is_leading,
  input  wire logic              in_is_trailing,
  input  wire logic signed [7:0] in_phase,
  input  wire logic [15:0]       in_dither,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [16:0]            out_fine_time,
  output logic [15:0]            out_bin_width_out,
  output logic                   out_recomputed,
  output logic [15:0]            out_min_width_out,
  output logic [15:0]            out_max_width_out,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  tdcc_pkg::ctl_t ctl;
  tdcc_pkg::sts_t sts;
  logic [15:0]    period_r, min_hits_r;

  // register port: period_total at 0x0, min_hits at 0x4
  assign pready = 1'b1;
  assign prdata = {16'd0, (paddr[2] == tdcc_pkg::REG_MIN_HITS) ? min_hits_r : period_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= tdcc_pkg::PERIOD_RESET;
      min_hits_r <= tdcc_pkg::MIN_HITS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == tdcc_pkg::REG_MIN_HITS) begin
        min_hits_r <= pwdata[15:0];
      end else begin
        period_r <= pwdata[15:0];
      end
    end
  end

  tdcc_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .sts, .ctl
  );

  tdcc_datapath #(.NUM_BINS(NUM_BINS)) u_dp (
    .clk, .rst_n, .ctl, .sts,
    .period(period_r), .min_hits(min_hits_r),
    .in_command, .in_is_leading, .in_is_trailing, .in_phase, .in_dither,
    .out_valid, .out_status, .out_fine_time, .out_bin_width_out,
    .out_recomputed, .out_min_width_out, .out_max_width_out
  );

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");
  a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
`endif

endmodule
`default_nettype wire

>>> src/tdcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tdcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/tdcc_div.sv
// Restoring divider, one quotient bit per cycle, 16-bit quotient.
`default_nettype none
module tdcc_div #(
  parameter int DW = 39
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DW+15:0]   dividend,
  input  wire logic [DW-1:0]    divisor,
  output logic      [15:0]      quotient,
  output logic                  done
);

  logic [DW:0]   rem_r, rem_nxt;
  logic [15:0]   nb_r, q_r;
  logic [3:0]    cnt_r;
  logic          run_r, done_r;
  logic [DW:0]   trial;

  // quotient is known to fit in 16 bits, so the top part starts below divisor
  always_comb begin
    trial = {rem_r[DW-1:0], nb_r[15]};
    rem_nxt = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == 4'd15);
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend[DW+15:16]};
      nb_r  <= dividend[15:0];
      q_r   <= '0;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      nb_r  <= {nb_r[14:0], 1'b0};
      q_r   <= {q_r[14:0], (trial >= {1'b0, divisor})};
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule
`default_nettype wire

>>> src/tdcc_datapath.sv
// Datapath: histogram memories, per-table registers, multiplier, divider.
`default_nettype none
module tdcc_datapath #(
  parameter int NUM_BINS = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tdcc_pkg::ctl_t     ctl,
  output tdcc_pkg::sts_t          sts,
  input  wire logic [15:0]        period,
  input  wire logic [15:0]        min_hits,
  input  wire logic [1:0]         in_command,
  input  wire logic               in_is_leading,
  input  wire logic               in_is_trailing,
  input  wire logic signed [7:0]  in_phase,
  input  wire logic [15:0]        in_dither,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [16:0]             out_fine_time,
  output logic [15:0]             out_bin_width_out,
  output logic                    out_recomputed,
  output logic [15:0]             out_min_width_out,
  output logic [15:0]             out_max_width_out
);

  localparam int BIW = $clog2(NUM_BINS);
  localparam int SIW = $clog2(NUM_BINS + 1);
  localparam int CAW = BIW + 2;
  localparam int SAW = SIW + 2;
  localparam int TW  = BIW + 32;

  // latched item
  logic [1:0]  cmd_r;
  logic        le_r, te_r, neg_r;
  logic [7:0]  mag_r;
  logic [15:0] dither_r;

  logic [SAW-1:0] sweep_r;
  logic [BIW-1:0] idx_r;
  logic [TW-1:0]  total_r;
  logic           acc_v_r;
  logic [TW+15:0] cum_r;
  logic [47:0]    prod_r;
  logic           cnt_nz_r;
  logic [15:0]    w_r, lo_r, hi_r;
  logic [7:0]     lp_r [4];
  logic [15:0]    nw_r [4];
  logic [15:0]    ww_r [4];

  logic [31:0]    c_rdata, c_wdata, mul_a;
  logic [15:0]    w_rdata, w_wdata, mul_b;
  logic [16:0]    s_rdata, s_wdata;
  logic [CAW-1:0] c_waddr, c_raddr, w_waddr, w_raddr;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [SIW-1:0] idx_p1;
  logic [15:0]    q;
  logic           div_done;
  logic           err, conv_ok;
  logic [1:0]     status;
  logic [8:0]     mag_ext;

  always_comb begin
    mag_ext = {1'b0, mag_r};
    err     = (mag_r == 8'd0) || (mag_ext >= 9'(NUM_BINS));
    if (cmd_r == tdcc_pkg::CMD_ACCUM || cmd_r == tdcc_pkg::CMD_CONVERT) begin
      status = (mag_r == 8'd0) ? tdcc_pkg::STS_ZERO :
               (err ? tdcc_pkg::STS_RANGE : tdcc_pkg::STS_OK);
    end else begin
      status = tdcc_pkg::STS_OK;
    end
    conv_ok = (cmd_r == tdcc_pkg::CMD_CONVERT) && !err && (le_r || te_r);
    idx_p1  = SIW'(idx_r) + SIW'(1);
  end

  always_comb begin
    sts.cmd        = cmd_r;
    sts.le         = le_r;
    sts.te         = te_r;
    sts.neg        = neg_r;
    sts.err        = err;
    sts.raise      = mag_r > lp_r[ctl.tsel];
    sts.sweep_last = &sweep_r;
    sts.idx_last   = idx_r == BIW'(NUM_BINS - 1);
    sts.total_ok   = (total_r != '0) && (total_r >= TW'(min_hits));
    sts.div_done   = div_done;
  end

  // memory ports
  always_comb begin
    c_waddr = ctl.clr_wr ? {sweep_r[SAW-1:SIW], sweep_r[BIW-1:0]}
                         : {ctl.tsel, mag_r[BIW-1:0]};
    c_wdata = ctl.clr_wr ? 32'd0 : ((&c_rdata) ? c_rdata : c_rdata + 32'd1);
    c_raddr = ctl.hit_rd ? {ctl.tsel, mag_r[BIW-1:0]} : {ctl.tsel, idx_r};
    w_waddr = ctl.clr_wr ? {sweep_r[SAW-1:SIW], sweep_r[BIW-1:0]}
                         : {ctl.tsel, idx_r};
    w_wdata = ctl.clr_wr ? tdcc_pkg::PERIOD_RESET : w_r;
    w_raddr = {ctl.tsel, mag_r[BIW-1:0]};
    s_waddr = ctl.clr_wr ? sweep_r : {ctl.tsel, idx_p1};
    s_wdata = ctl.clr_wr ? 17'd0 : {1'b0, q};
    s_raddr = {ctl.tsel, SIW'(mag_r)};
    mul_a   = ctl.conv_mul ? {16'd0, w_rdata} : c_rdata;
    mul_b   = ctl.conv_mul ? dither_r : period;
  end

  tdcc_ram #(.WIDTH(32), .DEPTH(4 << BIW)) u_counts (
    .clk, .we(ctl.clr_wr | ctl.hit_wr), .waddr(c_waddr), .wdata(c_wdata),
    .re(ctl.hit_rd | ctl.sum_rd | ctl.bin_rd), .raddr(c_raddr), .rdata(c_rdata)
  );

  tdcc_ram #(.WIDTH(16), .DEPTH(4 << BIW)) u_width (
    .clk, .we(ctl.clr_wr | ctl.bin_wr), .waddr(w_waddr), .wdata(w_wdata),
    .re(ctl.conv_rd), .raddr(w_raddr), .rdata(w_rdata)
  );

  tdcc_ram #(.WIDTH(17), .DEPTH(4 << SIW)) u_start (
    .clk, .we(ctl.clr_wr | ctl.bin_wr), .waddr(s_waddr), .wdata(s_wdata),
    .re(ctl.conv_rd), .raddr(s_raddr), .rdata(s_rdata)
  );

  tdcc_div #(.DW(TW)) u_div (
    .clk, .rst_n,
    .start(ctl.bin_acc | ctl.div_start_s),
    .dividend(ctl.div_start_s ? cum_r : (TW+16)'(prod_r)),
    .divisor(total_r),
    .quotient(q),
    .done(div_done)
  );

  // control-side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r   <= '0;
      acc_v_r   <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        lp_r[i] <= '0;
        nw_r[i] <= '0;
        ww_r[i] <= '0;
      end
    end else begin
      acc_v_r   <= ctl.sum_rd;
      out_valid <= ctl.emit;
      if (ctl.clr_wr) begin
        sweep_r <= sweep_r + SAW'(1);
      end
      if (ctl.hit_wr && sts.raise) begin
        lp_r[ctl.tsel] <= mag_r;
      end
      if (ctl.tbl_wr) begin
        nw_r[ctl.tsel] <= lo_r;
        ww_r[ctl.tsel] <= hi_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r    <= in_command;
      le_r     <= in_is_leading;
      te_r     <= in_is_trailing;
      neg_r    <= in_phase[7] || (in_phase == 8'sd0);
      mag_r    <= in_phase[7] ? 8'(-in_phase) : in_phase;
      dither_r <= in_dither;
    end
    if (ctl.sum_init || ctl.bin_init) begin
      idx_r <= '0;
    end else if (ctl.sum_rd || ctl.bin_wr) begin
      idx_r <= idx_r + BIW'(1);
    end
    if (ctl.sum_init) begin
      total_r <= '0;
    end else if (acc_v_r) begin
      total_r <= total_r + TW'(c_rdata);
    end
    if (ctl.bin_init) begin
      cum_r <= '0;
      lo_r  <= 16'hFFFF;
      hi_r  <= 16'd0;
    end else begin
      if (ctl.bin_acc) begin
        cum_r <= cum_r + (TW+16)'(prod_r);
      end
      if (ctl.bin_wr) begin
        if (w_r > hi_r) begin
          hi_r <= w_r;
        end
        if (cnt_nz_r && w_r < lo_r) begin
          lo_r <= w_r;
        end
      end
    end
    if (ctl.bin_mul || ctl.conv_mul) begin
      prod_r   <= mul_a * mul_b;
      cnt_nz_r <= c_rdata != 32'd0;
    end
    if (ctl.div_start_s) begin
      w_r <= q;
    end
    if (ctl.emit) begin
      out_status        <= status;
      out_recomputed    <= ctl.rec;
      out_fine_time     <= conv_ok ? s_rdata + {1'b0, prod_r[31:16]} : 17'd0;
      out_bin_width_out <= conv_ok ? w_rdata : 16'd0;
      out_min_width_out <= conv_ok ? nw_r[ctl.tsel] : 16'd0;
      out_max_width_out <= conv_ok ? ww_r[ctl.tsel] : 16'd0;
    end
  end

endmodule
`default_nettype wire

>>> src/tdcc_ctrl.sv
// Controller: sequences clear, hit, recompute and convert transactions.
`default_nettype none
module tdcc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire tdcc_pkg::sts_t sts,
  output tdcc_pkg::ctl_t      ctl
);

  tdcc_pkg::state_t state_r, state_nxt;
  logic [1:0]       tsel_r, tsel_nxt;
  logic             rec_r, rec_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdcc_pkg::ST_CLEAR;
      tsel_r  <= '0;
      rec_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tsel_r  <= tsel_nxt;
      rec_r   <= rec_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    tsel_nxt  = tsel_r;
    rec_nxt   = rec_r;
    ctl       = '0;
    ctl.tsel  = tsel_r;
    ctl.rec   = rec_r;
    busy      = state_r != tdcc_pkg::ST_IDLE;
    case (state_r)
      tdcc_pkg::ST_CLEAR: begin
        ctl.clr_wr = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = tdcc_pkg::ST_IDLE;
        end
      end
      tdcc_pkg::ST_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          rec_nxt   = 1'b0;
          state_nxt = tdcc_pkg::ST_DECODE;
        end
      end
      tdcc_pkg::ST_DECODE: begin
        state_nxt = tdcc_pkg::ST_RESP;
        if (sts.cmd == tdcc_pkg::CMD_RECOMPUTE) begin
          tsel_nxt  = 2'd0;
          state_nxt = tdcc_pkg::ST_PREP;
        end else if (sts.cmd == tdcc_pkg::CMD_ACCUM && !sts.err) begin
          if (sts.le) begin
            tsel_nxt  = {1'b0, sts.neg};
            state_nxt = tdcc_pkg::ST_HIT_RD;
          end else if (sts.te) begin
            tsel_nxt  = {1'b1, sts.neg};
            state_nxt = tdcc_pkg::ST_HIT_RD;
          end
        end else if (sts.cmd == tdcc_pkg::CMD_CONVERT && !sts.err
                     && (sts.le || sts.te)) begin
          tsel_nxt  = {sts.te, sts.neg};
          state_nxt = tdcc_pkg::ST_CONV_RD;
        end
      end
      tdcc_pkg::ST_HIT_RD: begin
        ctl.hit_rd = 1'b1;
        state_nxt  = tdcc_pkg::ST_HIT_WR;
      end
      tdcc_pkg::ST_HIT_WR: begin
        ctl.hit_wr = 1'b1;
        state_nxt  = sts.raise ? tdcc_pkg::ST_PREP : tdcc_pkg::ST_NEXT;
      end
      tdcc_pkg::ST_PREP: begin
        ctl.sum_init = 1'b1;
        state_nxt    = tdcc_pkg::ST_SUM;
      end
      tdcc_pkg::ST_SUM: begin
        ctl.sum_rd = 1'b1;
        if (sts.idx_last) begin
          state_nxt = tdcc_pkg::ST_SUM_END;
        end
      end
      tdcc_pkg::ST_SUM_END: begin
        state_nxt = tdcc_pkg::ST_TEST;
      end
      tdcc_pkg::ST_TEST: begin
        if (sts.total_ok) begin
          ctl.bin_init = 1'b1;
          rec_nxt      = 1'b1;
          state_nxt    = tdcc_pkg::ST_BIN_RD;
        end else begin
          state_nxt = tdcc_pkg::ST_NEXT;
        end
      end
      tdcc_pkg::ST_BIN_RD: begin
        ctl.bin_rd = 1'b1;
        state_nxt  = tdcc_pkg::ST_BIN_MUL;
      end
      tdcc_pkg::ST_BIN_MUL: begin
        ctl.bin_mul = 1'b1;
        state_nxt   = tdcc_pkg::ST_BIN_ACC;
      end
      tdcc_pkg::ST_BIN_ACC: begin
        ctl.bin_acc = 1'b1;
        state_nxt   = tdcc_pkg::ST_DIV_W;
      end
      tdcc_pkg::ST_DIV_W: begin
        if (sts.div_done) begin
          ctl.div_start_s = 1'b1;
          state_nxt       = tdcc_pkg::ST_DIV_S;
        end
      end
      tdcc_pkg::ST_DIV_S: begin
        if (sts.div_done) begin
          ctl.bin_wr = 1'b1;
          state_nxt  = sts.idx_last ? tdcc_pkg::ST_TBL : tdcc_pkg::ST_BIN_RD;
        end
      end
      tdcc_pkg::ST_TBL: begin
        ctl.tbl_wr = 1'b1;
        state_nxt  = tdcc_pkg::ST_NEXT;
      end
      tdcc_pkg::ST_NEXT: begin
        state_nxt = tdcc_pkg::ST_RESP;
        if (sts.cmd == tdcc_pkg::CMD_RECOMPUTE) begin
          if (tsel_r != 2'd3) begin
            tsel_nxt  = tsel_r + 2'd1;
            state_nxt = tdcc_pkg::ST_PREP;
          end
        end else if (!tsel_r[1] && sts.te) begin
          tsel_nxt  = {1'b1, sts.neg};
          state_nxt = tdcc_pkg::ST_HIT_RD;
        end
      end
      tdcc_pkg::ST_CONV_RD: begin
        ctl.conv_rd = 1'b1;
        state_nxt   = tdcc_pkg::ST_CONV_MUL;
      end
      tdcc_pkg::ST_CONV_MUL: begin
        ctl.conv_mul = 1'b1;
        state_nxt    = tdcc_pkg::ST_RESP;
      end
      tdcc_pkg::ST_RESP: begin
        ctl.emit  = 1'b1;
        state_nxt = tdcc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tdcc_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tdcc_pkg::ST_DIV_W && !sts.div_done) |=> state_r == tdcc_pkg::ST_DIV_W)
    else $error("left divider wait early");
  a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |=> !ctl.emit)
    else $error("result emitted twice");
  a_tbl_after_bin: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.tbl_wr |-> $past(ctl.bin_wr))
    else $error("table extremes stored without last bin");
`endif

endmodule
`default_nettype wire
